FILE: hdl/obb_overlap_separating_axis_unit_macros.svh
// ----------------------------------------------------------------------------
// obb overlap unit assertion macros
// shared immediate-consequence and next-cycle property wrappers
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_SEPARATING_AXIS_UNIT_MACROS_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OBB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define OBB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb package
// widths, addressing helpers and shared types for the box overlap unit
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   // axis component, column projection and corner projection widths
   localparam int AXIS_BITS  = 2 * VALUE_BITS + 1;
   localparam int Q_BITS     = AXIS_BITS + VALUE_BITS + 2;
   localparam int ACC_BITS   = Q_BITS + VALUE_BITS + 4;
   localparam int ELEMS      = 18;
   localparam int MEM_DEPTH  = 2 * ELEMS;
   localparam int ADDR_BITS  = $clog2(MEM_DEPTH);
   localparam int CNT_BITS   = $clog2(VALUE_BITS);

   localparam logic [4:0] ELEM_MAX0  = 5'd3;
   localparam logic [4:0] ELEM_XFORM = 5'd6;
   localparam logic [4:0] ELEM_LIMIT = 5'd18;
   localparam logic [ADDR_BITS-1:0] BOX_STRIDE = ADDR_BITS'(ELEMS);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   function automatic logic [ADDR_BITS-1:0] mem_addr(input logic box,
                                                     input logic [4:0] elem);
      mem_addr = (box ? BOX_STRIDE : '0) + ADDR_BITS'(elem);
   endfunction

   function automatic logic [4:0] xform_elem(input logic [1:0] row,
                                             input logic [1:0] col);
      xform_elem = ELEM_XFORM + {1'b0, row, 2'b00} + {3'b000, col};
   endfunction

   function automatic logic [1:0] next_row(input logic [1:0] r);
      next_row = (r == 2'd2) ? 2'd0 : r + 2'd1;
   endfunction

endpackage

FILE: hdl/obb_mul.sv
// ----------------------------------------------------------------------------
// obb shift-add multiplier
// signed wide multiplicand times signed value word, one bit per cycle
// ----------------------------------------------------------------------------
module obb_mul
   import obb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [ACC_BITS-1:0] mcand,
   input  logic [VALUE_BITS-1:0]      mplier,
   output logic signed [ACC_BITS-1:0] prod,
   output mul_status_type             status
);

   logic signed [ACC_BITS-1:0] acc_ff;
   logic signed [ACC_BITS-1:0] sh_ff;
   logic [VALUE_BITS-1:0]      mp_ff;
   logic [CNT_BITS-1:0]        cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic                       last;

   // top bit of the multiplier carries negative weight
   assign last = (cnt_ff == CNT_BITS'(VALUE_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         sh_ff  <= mcand;
         mp_ff  <= mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= last ? acc_ff - sh_ff : acc_ff + sh_ff;
         end
         sh_ff <= sh_ff <<< 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   assign prod        = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hdl/obb_overlap_separating_axis_unit.sv
// ----------------------------------------------------------------------------
// obb overlap separating axis unit
// oriented box pair overlap test over fifteen candidate axes
// ----------------------------------------------------------------------------
// usage
//  - request channel (req_valid/req_ready): kind 0 stores one signed value
//    word for box which_box at element (0-2 min, 3-5 max, 6-17 transform
//    row-major); element above 17 is dropped. kind 1 starts an evaluation
//  - a load gives no response
//  - an evaluation gives one response on rsp_valid/rsp_ready with collide
//  - evaluation work: per axis up to 42 products (6 to build a cross axis,
//    18 per box for column projections and extent terms); each product
//    is fetched, run on the bit-serial multiplier and written back, and
//    an early separating axis ends the pass of 15 axes sooner
//  - req_ready is low from the evaluate request until its response is taken
//  - a stalled receiver just holds rsp_valid and collide steady
//  - reset returns the sequencer to idle; box storage is not cleared and
//    must be loaded before an evaluation
// ----------------------------------------------------------------------------
`include "obb_overlap_separating_axis_unit_macros.svh"

module obb_overlap_separating_axis_unit
   import obb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic        req_which_box,
   input  logic [4:0]  req_element,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_collide
);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FETCH_A = 3'd1;
   localparam logic [2:0] ST_FETCH_B = 3'd2;
   localparam logic [2:0] ST_LOAD_B  = 3'd3;
   localparam logic [2:0] ST_MUL     = 3'd4;
   localparam logic [2:0] ST_WB      = 3'd5;
   localparam logic [2:0] ST_CHECK   = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   // work phases
   localparam logic [1:0] PH_AXIS = 2'd0;
   localparam logic [1:0] PH_Q    = 2'd1;
   localparam logic [1:0] PH_E    = 2'd2;

   logic [2:0] state_ff;
   logic [1:0] phase_ff;

   // axis walk: face columns of box 0 then box 1, then cross pairs
   logic       cross_ff;
   logic       ax_box_ff;
   logic [1:0] ax_i_ff;
   logic [1:0] ax_j_ff;
   // inner counters
   logic       box_ff;
   logic [1:0] r_ff;
   logic       t_ff;
   logic [1:0] c_ff;
   logic       mm_ff;
   logic       collide_ff;

   // box storage, value words of both boxes
   logic [VALUE_BITS-1:0] mem [MEM_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  addr_a;
   logic [ADDR_BITS-1:0]  addr_b;

   // datapath registers
   logic signed [AXIS_BITS-1:0] axis_ff [3];
   logic signed [Q_BITS-1:0]    q_ff [4];
   logic signed [ACC_BITS-1:0]  op_a_ff;
   logic signed [ACC_BITS-1:0]  p1_ff;
   logic signed [ACC_BITS-1:0]  lo_ff;
   logic signed [ACC_BITS-1:0]  hi_ff;
   logic signed [ACC_BITS-1:0]  lo0_ff;
   logic signed [ACC_BITS-1:0]  hi0_ff;

   logic                        face;
   logic [1:0]                  urow;
   logic [1:0]                  vrow;
   logic [4:0]                  ext_elem;
   logic signed [ACC_BITS-1:0]  rd_ext;
   logic signed [ACC_BITS-1:0]  op_a_in;
   logic signed [ACC_BITS-1:0]  prod;
   logic signed [AXIS_BITS-1:0] prod_axis;
   logic signed [Q_BITS-1:0]    prod_q;
   logic signed [Q_BITS-1:0]    q_in;
   logic signed [ACC_BITS-1:0]  pmin;
   logic signed [ACC_BITS-1:0]  pmax;
   logic                        separated;
   logic                        last_axis;
   logic                        mul_start;
   mul_status_type              mul_status;
   logic                        req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_collide = collide_ff;

   // operand addressing
   assign face     = !cross_ff;
   assign urow     = t_ff ? next_row(next_row(r_ff)) : next_row(r_ff);
   assign vrow     = t_ff ? next_row(r_ff) : next_row(next_row(r_ff));
   assign ext_elem = {3'b000, c_ff} + (mm_ff ? ELEM_MAX0 : 5'd0);

   always_comb begin
      if (face) begin
         addr_a = mem_addr(ax_box_ff, xform_elem(r_ff, ax_i_ff));
      end else begin
         addr_a = mem_addr(1'b0, xform_elem(urow, ax_i_ff));
      end
      case (phase_ff)
         PH_AXIS: addr_b = mem_addr(1'b1, xform_elem(vrow, ax_j_ff));
         PH_Q:    addr_b = mem_addr(box_ff, xform_elem(r_ff, c_ff));
         PH_E:    addr_b = mem_addr(box_ff, ext_elem);
         default: addr_b = '0;
      endcase
   end

   assign rd_addr = (state_ff == ST_FETCH_A) ? addr_a : addr_b;
   assign rd_ext  = ACC_BITS'(signed'(rd_data_ff));

   always_comb begin
      case (phase_ff)
         PH_AXIS: op_a_in = rd_ext;
         PH_Q:    op_a_in = ACC_BITS'(axis_ff[r_ff]);
         PH_E:    op_a_in = ACC_BITS'(q_ff[c_ff]);
         default: op_a_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_kind == KIND_LOAD && req_element < ELEM_LIMIT) begin
         mem[mem_addr(req_which_box, req_element)] <= req_value[VALUE_BITS-1:0];
      end
      rd_data_ff <= mem[rd_addr];
   end

   // shared multiplier
   assign mul_start = (state_ff == ST_LOAD_B);

   obb_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (op_a_ff),
      .mplier (rd_data_ff),
      .prod   (prod),
      .status (mul_status)
   );

   assign prod_axis = prod[AXIS_BITS-1:0];
   assign prod_q    = prod[Q_BITS-1:0];
   assign q_in      = (r_ff == 2'd0) ? prod_q : q_ff[c_ff] + prod_q;
   assign pmin      = (p1_ff < prod) ? p1_ff : prod;
   assign pmax      = (p1_ff < prod) ? prod : p1_ff;
   assign separated = (hi0_ff < lo_ff) || (hi_ff < lo0_ff);
   assign last_axis = cross_ff && ax_i_ff == 2'd2 && ax_j_ff == 2'd2;

   // sequencer and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_kind == KIND_EVAL) begin
                  state_ff  <= ST_FETCH_A;
                  phase_ff  <= PH_AXIS;
                  cross_ff  <= 1'b0;
                  ax_box_ff <= 1'b0;
                  ax_i_ff   <= 2'd0;
                  ax_j_ff   <= 2'd0;
                  box_ff    <= 1'b0;
                  r_ff      <= 2'd0;
                  t_ff      <= 1'b0;
                  c_ff      <= 2'd0;
                  mm_ff     <= 1'b0;
               end
            end
            ST_FETCH_A: state_ff <= ST_FETCH_B;
            ST_FETCH_B: begin
               // face axis words go straight to writeback
               state_ff <= (phase_ff == PH_AXIS && face) ? ST_WB : ST_LOAD_B;
            end
            ST_LOAD_B: state_ff <= ST_MUL;
            ST_MUL: begin
               if (mul_status.done) begin
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               state_ff <= ST_FETCH_A;
               case (phase_ff)
                  PH_AXIS: begin
                     if (face || t_ff) begin
                        t_ff <= 1'b0;
                        r_ff <= next_row(r_ff);
                        if (r_ff == 2'd2) begin
                           phase_ff <= PH_Q;
                           c_ff     <= 2'd0;
                        end
                     end else begin
                        t_ff <= 1'b1;
                     end
                  end
                  PH_Q: begin
                     r_ff <= next_row(r_ff);
                     if (r_ff == 2'd2) begin
                        c_ff <= c_ff + 2'd1;
                        if (c_ff == 2'd3) begin
                           phase_ff <= PH_E;
                           mm_ff    <= 1'b0;
                        end
                     end
                  end
                  PH_E: begin
                     mm_ff <= !mm_ff;
                     if (mm_ff) begin
                        c_ff <= c_ff + 2'd1;
                        if (c_ff == 2'd2) begin
                           state_ff <= ST_CHECK;
                        end
                     end
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_CHECK: begin
               r_ff <= 2'd0;
               c_ff <= 2'd0;
               t_ff <= 1'b0;
               if (!box_ff) begin
                  box_ff   <= 1'b1;
                  phase_ff <= PH_Q;
                  state_ff <= ST_FETCH_A;
               end else if (separated) begin
                  collide_ff <= 1'b0;
                  state_ff   <= ST_DONE;
               end else if (last_axis) begin
                  collide_ff <= 1'b1;
                  state_ff   <= ST_DONE;
               end else begin
                  box_ff   <= 1'b0;
                  phase_ff <= PH_AXIS;
                  state_ff <= ST_FETCH_A;
                  // step to the next candidate axis
                  if (!cross_ff) begin
                     ax_i_ff <= next_row(ax_i_ff);
                     if (ax_i_ff == 2'd2) begin
                        if (ax_box_ff) begin
                           cross_ff <= 1'b1;
                           ax_j_ff  <= 2'd0;
                        end
                        ax_box_ff <= 1'b1;
                     end
                  end else begin
                     ax_j_ff <= next_row(ax_j_ff);
                     if (ax_j_ff == 2'd2) begin
                        ax_i_ff <= next_row(ax_i_ff);
                     end
                  end
               end
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath writes
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH_B) begin
         op_a_ff <= op_a_in;
      end
      if (state_ff == ST_WB) begin
         case (phase_ff)
            PH_AXIS: begin
               if (face) begin
                  axis_ff[r_ff] <= AXIS_BITS'(op_a_ff);
               end else if (!t_ff) begin
                  axis_ff[r_ff] <= prod_axis;
               end else begin
                  axis_ff[r_ff] <= axis_ff[r_ff] - prod_axis;
               end
            end
            PH_Q: begin
               q_ff[c_ff] <= q_in;
               // translation column seeds both range ends
               if (c_ff == 2'd3 && r_ff == 2'd2) begin
                  lo_ff <= ACC_BITS'(q_in) <<< FRAC_BITS;
                  hi_ff <= ACC_BITS'(q_in) <<< FRAC_BITS;
               end
            end
            PH_E: begin
               if (!mm_ff) begin
                  p1_ff <= prod;
               end else begin
                  lo_ff <= lo_ff + pmin;
                  hi_ff <= hi_ff + pmax;
               end
            end
            default: p1_ff <= p1_ff;
         endcase
      end
      if (state_ff == ST_CHECK && !box_ff) begin
         lo0_ff <= lo_ff;
         hi0_ff <= hi_ff;
      end
   end

   // checks
   `OBB_ASSERT_SAME(a_rsp_not_ready, clock, reset, rsp_valid, !req_ready, "ready during response")
   `OBB_ASSERT_NEXT(a_eval_busy, clock, reset, req_fire && req_kind == KIND_EVAL, !req_ready, "ready after evaluate")
   `OBB_ASSERT_NEXT(a_rsp_release, clock, reset, rsp_valid && rsp_ready, req_ready, "not idle after response")
   `OBB_ASSERT_SAME(a_mul_wait, clock, reset, state_ff == ST_MUL, mul_status.busy || mul_status.done, "multiplier idle while waited on")

endmodule
